### rtl/core/ftp_pkg.sv
package ftp_pkg;

  // default sizes of the queue
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  // fixed field widths at the ports
  localparam int CMD_W     = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int REMOVED_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_PURGE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_EMPTY_ERR = 2'd1,
    RES_FULL_ERR  = 2'd2
  } res_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_PURGE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic        do_put;
    logic        do_get;
    logic        do_purge_start;
    logic        imm_result;
    res_status_t res_status;
    logic        get_load;
    logic        purge_step;
    logic        purge_last;
  } ftp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic empty;
    logic full;
    logic scan_last;
  } ftp_stat_t;

endpackage

### rtl/core/fifo_with_threshold_purge_unit.sv
// bounded first-in first-out queue of signed words with a threshold purge.
// each input word carries a command and a value: put appends the value,
// get pops the oldest entry and returns it, purge deletes every entry
// strictly greater than the value (signed) and keeps the rest in order.
// exactly one result word comes back per input word, carrying a status
// (ok, get on empty, put on full), the popped value, the purge count and
// whether the queue is empty afterwards. put and any error or no-op
// command load the result at once, so puts stream back to back; get
// passes through a second state because the entry store is a ram with
// a registered read; purge walks the queue through the single ram read
// port, one entry per cycle, compacting survivors in place through the
// write port. no input word is taken while a get or purge is in flight,
// or while a finished result is held by a stall on the result side. the
// entry store has no reset; only the pointers, the count and the result
// valid flag are cleared.
module fifo_with_threshold_purge_unit #(
  parameter int QUEUE_DEPTH = ftp_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = ftp_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ftp_pkg::CMD_W-1:0]           in_command,
  input  logic signed [ftp_pkg::VALUE_W-1:0]  in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ftp_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ftp_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ftp_pkg::REMOVED_W-1:0]       out_removed_count,
  output logic                                out_is_empty
);

  import ftp_pkg::*;

  // command and status between sequencer and datapath
  ftp_cmd_t  cmd;
  ftp_stat_t stat;

  // sequencer: decodes commands, runs the get and purge walks
  ftp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: pointers, count, entry ram, purge compaction, result register
  ftp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_value          (in_value),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_removed_count (out_removed_count),
    .out_is_empty      (out_is_empty)
  );

endmodule

### rtl/core/ftp_ram.sv
module ftp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ftp_ctrl.sv
module ftp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [ftp_pkg::CMD_W-1:0]   in_command,
  output logic                        in_stall,
  input  ftp_pkg::ftp_stat_t          stat,
  output ftp_pkg::ftp_cmd_t           cmd
);

  import ftp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = !((state_r == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_code_t'(in_command))
            CMD_GET:   if (!stat.empty) state_nxt = S_GET;
            CMD_PURGE: if (!stat.empty) state_nxt = S_PURGE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_GET:   state_nxt = S_IDLE;
      S_PURGE: if (stat.scan_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.res_status = RES_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_code_t'(in_command))
            CMD_PUT: begin
              cmd.imm_result = 1'b1;
              if (stat.full) begin
                cmd.res_status = RES_FULL_ERR;
              end else begin
                cmd.do_put = 1'b1;
              end
            end
            CMD_GET: begin
              if (stat.empty) begin
                cmd.imm_result = 1'b1;
                cmd.res_status = RES_EMPTY_ERR;
              end else begin
                cmd.do_get = 1'b1;
              end
            end
            CMD_PURGE: begin
              if (stat.empty) begin
                cmd.imm_result = 1'b1;
              end else begin
                cmd.do_purge_start = 1'b1;
              end
            end
            default: cmd.imm_result = 1'b1;
          endcase
        end
      end
      S_GET: cmd.get_load = 1'b1;
      S_PURGE: begin
        cmd.purge_step = 1'b1;
        cmd.purge_last = stat.scan_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ftp_dp.sv
module ftp_dp #(
  parameter int QUEUE_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [ftp_pkg::VALUE_W-1:0]  in_value,
  input  ftp_pkg::ftp_cmd_t                   cmd,
  output ftp_pkg::ftp_stat_t                  stat,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [ftp_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ftp_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ftp_pkg::REMOVED_W-1:0]       out_removed_count,
  output logic                                out_is_empty
);

  import ftp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] scan_r, scan_nxt, wscan_r, wscan_nxt;
  logic [CW-1:0] idx_r, idx_nxt, kept_r, kept_nxt, rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] thr_r, thr_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, rd_data, in_data;
  logic [VALUE_W-1:0]    rd_value;
  logic [REMOVED_W-1:0]  rem_out;
  logic                  keep;
  logic                  load_out;

  logic                  out_valid_r;
  res_status_t           out_status_r;
  logic [VALUE_W-1:0]    out_read_value_r;
  logic [REMOVED_W-1:0]  out_removed_r;
  logic                  out_is_empty_r;

  // bring words to storage width and back, two's complement
  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign in_data = in_value[DATA_WIDTH-1:0];
    end else begin : g_wide
      assign in_data = {{(DATA_WIDTH - VALUE_W){in_value[VALUE_W-1]}}, in_value};
    end
    if (DATA_WIDTH >= VALUE_W) begin : g_rd_trunc
      assign rd_value = rd_data[VALUE_W-1:0];
    end else begin : g_rd_ext
      assign rd_value = {{(VALUE_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
    end
    if (CW >= REMOVED_W) begin : g_rem_trunc
      assign rem_out = rem_nxt[REMOVED_W-1:0];
    end else begin : g_rem_ext
      assign rem_out = {{(REMOVED_W - CW){1'b0}}, rem_nxt};
    end
  endgenerate

  ftp_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // entries above the threshold are dropped
  assign keep = !($signed(rd_data) > $signed(thr_r));

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.empty     = (cnt_r == '0);
  assign stat.full      = (cnt_r == FULL_CNT);
  assign stat.scan_last = ((idx_r + 1'b1) == cnt_r);

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    thr_nxt   = thr_r;
    scan_nxt  = scan_r;
    wscan_nxt = wscan_r;
    idx_nxt   = idx_r;
    kept_nxt  = kept_r;
    rem_nxt   = rem_r;
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = in_data;
    ram_raddr = rp_r;
    if (cmd.do_put) begin
      ram_we  = 1'b1;
      wp_nxt  = ptr_inc(wp_r);
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.do_get) begin
      rp_nxt  = ptr_inc(rp_r);
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.do_purge_start) begin
      thr_nxt   = in_data;
      scan_nxt  = rp_r;
      wscan_nxt = rp_r;
      idx_nxt   = '0;
      kept_nxt  = '0;
      rem_nxt   = '0;
    end
    if (cmd.purge_step) begin
      // fetch the next entry while the current one is compacted
      scan_nxt  = ptr_inc(scan_r);
      ram_raddr = scan_nxt;
      idx_nxt   = idx_r + 1'b1;
      if (keep) begin
        ram_we    = 1'b1;
        ram_waddr = wscan_r;
        ram_wdata = rd_data;
        wscan_nxt = ptr_inc(wscan_r);
        kept_nxt  = kept_r + 1'b1;
      end else begin
        rem_nxt = rem_r + 1'b1;
      end
      if (cmd.purge_last) begin
        cnt_nxt = kept_nxt;
        wp_nxt  = wscan_nxt;
      end
    end
  end

  assign load_out = cmd.imm_result || cmd.get_load || cmd.purge_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_r   <= thr_nxt;
    scan_r  <= scan_nxt;
    wscan_r <= wscan_nxt;
    idx_r   <= idx_nxt;
    kept_r  <= kept_nxt;
    rem_r   <= rem_nxt;
    if (load_out) begin
      out_status_r     <= cmd.res_status;
      out_read_value_r <= cmd.get_load ? rd_value : '0;
      out_removed_r    <= cmd.purge_last ? rem_out : '0;
      out_is_empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_read_value_r;
  assign out_removed_count = out_removed_r;
  assign out_is_empty      = out_is_empty_r;

endmodule
